### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. The checks compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Implication checked in the same cycle, outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

  // register map (word index on the APB port)
  localparam int unsigned REG_TIMEOUT  = 0;
  localparam int unsigned REG_MAX_DIST = 1;
  localparam int unsigned REG_PRE_LOW  = 2;
  localparam int unsigned REG_PULSE    = 3;
  localparam int unsigned REG_IDX_W    = 2;
  localparam int unsigned PADDR_W      = 4;
  localparam int unsigned PDATA_W      = 32;

  // register widths
  localparam int unsigned TIMEOUT_W  = 20;
  localparam int unsigned MAX_DIST_W = 10;
  localparam int unsigned TICK8_W    = 8;
  localparam int unsigned DIST_W     = 14;

  // register reset values
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 20'd30000;
  localparam logic [MAX_DIST_W-1:0] MAX_DIST_RST = 10'd400;
  localparam logic [TICK8_W-1:0]    PRE_LOW_RST  = 8'd5;
  localparam logic [TICK8_W-1:0]    PULSE_RST    = 8'd15;

  localparam int unsigned COUNTER_BITS_DEF = 20;

  // distance = (ticks * 1124) >> 12, about 0.01715 cm per us in 1/16 cm
  localparam int unsigned DIST_SCALE   = 1124;
  localparam int unsigned DIST_SCALE_W = 11;
  localparam int unsigned DIST_SHIFT   = 12;
  localparam int unsigned DIST_MIN     = 32;  // 2 cm

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_PRE_LOW   = 5'b00010,
    PH_PULSE     = 5'b00100,
    PH_WAIT_RISE = 5'b01000,
    PH_HIGH      = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic              tmo;
    logic [DIST_W-1:0] distance;
  } result_t;

endpackage

`default_nettype wire

### rtl/ultrasonic_echo_ranger.sv
`default_nettype none
`include "assert_macros.svh"

// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------
// input    | in_valid / in_stall | start_req, echo_level (one us tick)
// output   | out_valid/out_stall | trigger_out, busy_res, done_res,
//          |                     | timed_out, distance_sixteenths
// config   | APB write/read      | paddr, pwdata, prdata
//
// One tick in, one result out. A tick is held in the input register, then
// the phase/counter update and the distance multiply-and-clamp land in
// the result register: one tick per cycle sustained unless back-pressure
// fills the output side's second (skid) register, which lets ticks keep
// flowing while one result waits; in_stall rises only when the skid register
// and the input register are both full.
// rst is synchronous: phase idle, counter and last distance zero, registers
// to their defaults, all buffers empty.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // tick input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        start_req,
  input  logic                        echo_level,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        trigger_out,
  output logic                        busy_res,
  output logic                        done_res,
  output logic                        timed_out,
  output logic [uer_pkg::DIST_W-1:0]  distance_sixteenths,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uer_pkg::PADDR_W-1:0] paddr,
  input  logic [uer_pkg::PDATA_W-1:0] pwdata,
  output logic [uer_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import uer_pkg::*;

  localparam int unsigned CW     = COUNTER_BITS;
  localparam int unsigned CMP_W  = (CW > TIMEOUT_W) ? CW : TIMEOUT_W;
  localparam int unsigned PROD_W = CW + DIST_SCALE_W;

  localparam logic [CW-1:0]     CNT_MAX   = {CW{1'b1}};
  localparam logic [PROD_W-1:0] SCALE     = PROD_W'(DIST_SCALE);
  localparam logic [PROD_W-1:0] MIN_D     = PROD_W'(DIST_MIN);

  // ---------------------------------------------------------------- config
  logic [TIMEOUT_W-1:0]  timeout_ticks;
  logic [MAX_DIST_W-1:0] max_distance_cm;
  logic [TICK8_W-1:0]    pre_low_ticks;
  logic [TICK8_W-1:0]    pulse_ticks;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RST;
      max_distance_cm <= MAX_DIST_RST;
      pre_low_ticks   <= PRE_LOW_RST;
      pulse_ticks     <= PULSE_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_IDX_W'(REG_TIMEOUT):  timeout_ticks   <= pwdata[TIMEOUT_W-1:0];
        REG_IDX_W'(REG_MAX_DIST): max_distance_cm <= pwdata[MAX_DIST_W-1:0];
        REG_IDX_W'(REG_PRE_LOW):  pre_low_ticks   <= pwdata[TICK8_W-1:0];
        REG_IDX_W'(REG_PULSE):    pulse_ticks     <= pwdata[TICK8_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IDX_W'(REG_TIMEOUT):  prdata = PDATA_W'(timeout_ticks);
      REG_IDX_W'(REG_MAX_DIST): prdata = PDATA_W'(max_distance_cm);
      REG_IDX_W'(REG_PRE_LOW):  prdata = PDATA_W'(pre_low_ticks);
      REG_IDX_W'(REG_PULSE):    prdata = PDATA_W'(pulse_ticks);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- input register
  logic s1_valid;
  logic s1_start;
  logic s1_echo;
  logic skid_valid;
  logic adv;        // tick in the input register is processed this cycle
  logic in_take;

  assign in_stall = s1_valid && skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign adv      = s1_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_start <= start_req;
      s1_echo  <= echo_level;
    end
  end

  // ---------------------------------------------------------- measurement
  phase_t          phase, phase_next;
  logic [CW-1:0]   tick_counter, tick_counter_next;
  logic [DIST_W-1:0] last_distance, last_distance_next;
  result_t         res;

  function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
    cnt_inc = (c == CNT_MAX) ? c : c + CW'(1);
  endfunction

  function automatic logic expired(input logic [CW-1:0] c,
                                   input logic [TIMEOUT_W-1:0] lim);
    expired = (CMP_W'(c) > CMP_W'(lim)) || (c == CNT_MAX);
  endfunction

  // distance from the current high count: one multiply, then the two clamps
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] dist_raw;
  logic [PROD_W-1:0] dist_lo;
  logic [PROD_W-1:0] dist_hi;
  logic [DIST_W-1:0] dist_cl;

  assign prod     = PROD_W'(tick_counter) * SCALE;
  assign dist_raw = prod >> DIST_SHIFT;
  assign dist_lo  = (dist_raw < MIN_D) ? MIN_D : dist_raw;
  assign dist_hi  = PROD_W'({max_distance_cm, 4'b0000});
  // upper clamp last, so a maximum below 2 cm wins
  assign dist_cl  = (dist_lo > dist_hi) ? dist_hi[DIST_W-1:0] : dist_lo[DIST_W-1:0];

  always_comb begin
    logic trig;
    logic done;
    logic tmo;
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    last_distance_next = last_distance;
    trig = 1'b0;
    done = 1'b0;
    tmo  = 1'b0;

    if (phase == PH_IDLE && s1_start) begin
      phase_next        = PH_PRE_LOW;
      tick_counter_next = '0;
    end
    // zero pre-low time falls straight through to the pulse
    if (phase_next == PH_PRE_LOW && tick_counter_next >= CW'(pre_low_ticks)) begin
      phase_next        = PH_PULSE;
      tick_counter_next = '0;
    end

    case (phase_next)
      PH_IDLE: ;
      PH_PRE_LOW: tick_counter_next = cnt_inc(tick_counter_next);
      PH_PULSE: begin
        trig              = 1'b1;
        tick_counter_next = cnt_inc(tick_counter_next);
        if (tick_counter_next >= CW'(pulse_ticks)) begin
          phase_next        = PH_WAIT_RISE;
          tick_counter_next = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (s1_echo) begin
          phase_next        = PH_HIGH;
          tick_counter_next = CW'(1);
        end else if (expired(tick_counter_next, timeout_ticks)) begin
          phase_next         = PH_IDLE;
          done               = 1'b1;
          tmo                = 1'b1;
          last_distance_next = '0;
          tick_counter_next  = '0;
        end else begin
          tick_counter_next = cnt_inc(tick_counter_next);
        end
      end
      PH_HIGH: begin
        // counter is untouched by the start logic here, so dist_cl applies
        if (!s1_echo) begin
          phase_next         = PH_IDLE;
          done               = 1'b1;
          last_distance_next = dist_cl;
          tick_counter_next  = '0;
        end else if (expired(tick_counter_next, timeout_ticks)) begin
          phase_next         = PH_IDLE;
          done               = 1'b1;
          tmo                = 1'b1;
          last_distance_next = '0;
          tick_counter_next  = '0;
        end else begin
          tick_counter_next = cnt_inc(tick_counter_next);
        end
      end
      default: begin
        phase_next        = PH_IDLE;
        tick_counter_next = '0;
      end
    endcase

    res.trigger  = trig;
    res.busy     = (phase_next != PH_IDLE);
    res.done     = done;
    res.tmo      = tmo;
    res.distance = last_distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_counter  <= '0;
      last_distance <= '0;
    end else if (adv) begin
      phase         <= phase_next;
      tick_counter  <= tick_counter_next;
      last_distance <= last_distance_next;
    end
  end

  // ---------------------------------------------------------- output + skid
  result_t out_q;
  result_t skid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        // output drained: refill from skid, or from a fresh result
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= adv;
        end
      end else if (!out_valid) begin
        out_valid <= adv;
      end else if (adv) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall && skid_valid) begin
      out_q <= skid_q;
    end else if (adv && !(out_valid && out_stall)) begin
      out_q <= res;
    end
    if (adv && out_valid && out_stall) begin
      skid_q <= res;
    end
  end

  assign trigger_out         = out_q.trigger;
  assign busy_res            = out_q.busy;
  assign done_res            = out_q.done;
  assign timed_out           = out_q.tmo;
  assign distance_sixteenths = out_q.distance;

  // ---------------------------------------------------------- checks
  `ASSERT_IMPL(a_skid_needs_out, clk, rst, skid_valid, out_valid)
  `ASSERT_IMPL(a_done_ends_busy, clk, rst, out_valid && done_res, !busy_res)
  `ASSERT_IMPL(a_tmo_zero, clk, rst, out_valid && timed_out,
               done_res && distance_sixteenths == '0)
  `ASSERT_IMPL(a_trig_busy, clk, rst, out_valid && trigger_out, busy_res && !done_res)
  `ASSERT_RST(a_stall_full, clk, rst, !in_stall || (s1_valid && out_valid))

endmodule

`default_nettype wire

### bench/echo_range_checker.sv
`timescale 1ns / 1ps

module echo_range_checker #(
  parameter int unsigned COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        start_req,
  input  logic                        echo_level,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        trigger_out,
  input  logic                        busy_res,
  input  logic                        done_res,
  input  logic                        timed_out,
  input  logic [uer_pkg::DIST_W-1:0]  distance_sixteenths,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uer_pkg::PADDR_W-1:0] paddr,
  input  logic [uer_pkg::PDATA_W-1:0] pwdata,
  input  logic [uer_pkg::PDATA_W-1:0] prdata,
  input  logic                        pready,
  output int unsigned                 failures,
  output int unsigned                 results_owed,
  output logic                        ranger_idle,
  output int unsigned                 done_count,
  output int unsigned                 timeout_count
);
  import uer_pkg::*;

  // 0.01715 cm per us, in 1/16 cm, Q12
  localparam logic [63:0] SIXTEENTHS_PER_TICK_Q12 = 64'd1124;
  localparam int unsigned Q12_SHIFT = 12;
  localparam logic [63:0] FLOOR_SIXTEENTHS = 64'd32;  // 2 cm

  logic [TIMEOUT_W-1:0]    timeout_ticks;
  logic [MAX_DIST_W-1:0]   max_cm;
  logic [TICK8_W-1:0]      pre_low_ticks;
  logic [TICK8_W-1:0]      pulse_ticks;
  phase_t                  phase;
  logic [COUNTER_BITS-1:0] elapsed;
  logic [DIST_W-1:0]       last_dist;
  result_t                 tick_results[$];

  function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // a wait also fails once the counter pins at full scale
  function automatic logic wait_over();
    return (elapsed > timeout_ticks) || (elapsed == '1);
  endfunction

  function automatic result_t ranging_step(input logic start, input logic echo);
    result_t     r;
    logic [63:0] d;
    logic [63:0] ceiling;
    r = '0;
    if (phase == PH_IDLE && start) begin
      phase = PH_PRE_LOW;
      elapsed = '0;
    end
    if (phase == PH_PRE_LOW && elapsed >= pre_low_ticks) begin
      phase = PH_PULSE;
      elapsed = '0;
    end
    case (phase)
      PH_PRE_LOW: elapsed = bump(elapsed);
      PH_PULSE: begin
        r.trigger = 1'b1;
        elapsed = bump(elapsed);
        if (elapsed >= pulse_ticks) begin
          phase = PH_WAIT_RISE;
          elapsed = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase = PH_HIGH;
          elapsed = COUNTER_BITS'(1);
        end else if (wait_over()) begin
          phase = PH_IDLE;
          r.done = 1'b1;
          r.tmo = 1'b1;
          last_dist = '0;
          elapsed = '0;
        end else begin
          elapsed = bump(elapsed);
        end
      end
      PH_HIGH: begin
        if (!echo) begin
          d = (64'(elapsed) * SIXTEENTHS_PER_TICK_Q12) >> Q12_SHIFT;
          ceiling = 64'(max_cm) * 64'd16;
          if (d < FLOOR_SIXTEENTHS) d = FLOOR_SIXTEENTHS;
          if (d > ceiling) d = ceiling;  // ceiling goes last, so it wins below 2 cm
          phase = PH_IDLE;
          r.done = 1'b1;
          last_dist = d[DIST_W-1:0];
          elapsed = '0;
        end else if (wait_over()) begin
          phase = PH_IDLE;
          r.done = 1'b1;
          r.tmo = 1'b1;
          last_dist = '0;
          elapsed = '0;
        end else begin
          elapsed = bump(elapsed);
        end
      end
      default: ;
    endcase
    r.busy = (phase != PH_IDLE);
    r.distance = last_dist;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t            want;
    result_t            got;
    logic [PDATA_W-1:0] reg_value;
    if (rst) begin
      timeout_ticks = 20'd30000;
      max_cm = 10'd400;
      pre_low_ticks = 8'd5;
      pulse_ticks = 8'd15;
      phase = PH_IDLE;
      elapsed = '0;
      last_dist = '0;
      tick_results.delete();
      failures = 0;
      done_count = 0;
      timeout_count = 0;
    end else begin
      // register transfer: writes land, reads must show the current value
      if (psel && penable && pready) begin
        case (paddr[2 +: REG_IDX_W])
          REG_IDX_W'(REG_TIMEOUT):  reg_value = PDATA_W'(timeout_ticks);
          REG_IDX_W'(REG_MAX_DIST): reg_value = PDATA_W'(max_cm);
          REG_IDX_W'(REG_PRE_LOW):  reg_value = PDATA_W'(pre_low_ticks);
          REG_IDX_W'(REG_PULSE):    reg_value = PDATA_W'(pulse_ticks);
          default:                  reg_value = '0;
        endcase
        if (pwrite) begin
          case (paddr[2 +: REG_IDX_W])
            REG_IDX_W'(REG_TIMEOUT):  timeout_ticks = pwdata[TIMEOUT_W-1:0];
            REG_IDX_W'(REG_MAX_DIST): max_cm = pwdata[MAX_DIST_W-1:0];
            REG_IDX_W'(REG_PRE_LOW):  pre_low_ticks = pwdata[TICK8_W-1:0];
            REG_IDX_W'(REG_PULSE):    pulse_ticks = pwdata[TICK8_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_value) begin
          failures++;
          if (failures <= 10)
            $display("%0t: readback of register %0d: expected %h, got %h",
                     $time, paddr[2 +: REG_IDX_W], reg_value, prdata);
        end
      end

      if (out_valid && !out_stall) begin
        got = {trigger_out, busy_res, done_res, timed_out, distance_sixteenths};
        if (tick_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = tick_results.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: tick result (expected/actual): trigger %b/%b busy %b/%b",
                        " done %b/%b timed_out %b/%b distance %0d/%0d"},
                       $time, want.trigger, got.trigger, want.busy, got.busy,
                       want.done, got.done, want.tmo, got.tmo,
                       want.distance, got.distance);
          end
        end
      end

      if (in_valid && !in_stall) begin
        want = ranging_step(start_req, echo_level);
        tick_results.push_back(want);
        if (want.done) done_count++;
        if (want.tmo) timeout_count++;
      end
    end
    results_owed = tick_results.size();
    ranger_idle = (phase == PH_IDLE);
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import uer_pkg::*;

  localparam int unsigned RANDOM_TICKS = 700;
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  // hang limit for the worst correct run (long gaps and stalls on every tick)
  localparam longint unsigned LIMIT_NS = 64'd20_000_000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               start_req;
  logic               echo_level;
  logic               out_valid;
  logic               out_stall;
  logic               trigger_out;
  logic               busy_res;
  logic               done_res;
  logic               timed_out;
  logic [DIST_W-1:0]  distance_sixteenths;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned failures;
  int unsigned results_owed;
  logic        ranger_idle;
  int unsigned done_count;
  int unsigned timeout_count;

  // what the stimulus needs of the current register settings
  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [TICK8_W-1:0]   pre_low_ticks;
  logic [TICK8_W-1:0]   pulse_ticks;

  logic        tx_gaps = 1'b0;   // sender idles at random
  logic        rx_gaps = 1'b0;   // receiver stalls at random
  logic        hold_req = 1'b0;  // ask the receiver for one long hold-off
  int unsigned stall_left = 0;
  int unsigned ticks_sent = 0;
  int unsigned reg_writes = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ultrasonic_echo_ranger dut (.*);

  echo_range_checker checker_i (.*);

  // ---------------------------------------------------------------------------
  // Tick sender. Everything changes at the falling edge; a transfer is seen at
  // the rising edge through the pre-edge value of in_stall. Tasks start and
  // end on a falling edge, so in_valid gets at most one update per step.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic start, input logic echo);
    int unsigned gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      // mostly short gaps, now and then a long one; payload is junk meanwhile
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      start_req <= 1'($urandom);
      echo_level <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    start_req <= start;
    echo_level <= echo;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    ticks_sent++;
  endtask

  // One measurement as the sensor would produce it: the start tick, the
  // trigger ticks (echo is don't-care there), rise_wait ticks of echo low,
  // high_len ticks of echo high, then echo low to close the pulse. Extra
  // starts sprinkled in must be ignored while busy.
  task automatic measure(input int unsigned rise_wait, input int unsigned high_len);
    int unsigned trig_ticks;
    trig_ticks = pre_low_ticks + ((pulse_ticks == 0) ? 1 : pulse_ticks);
    send_tick(1'b1, 1'($urandom));
    repeat (trig_ticks - 1) send_tick(1'($urandom_range(0, 3) == 0), 1'($urandom));
    repeat (rise_wait) send_tick(1'($urandom_range(0, 3) == 0), 1'b0);
    repeat (high_len) send_tick(1'($urandom_range(0, 3) == 0), 1'b1);
    if (high_len != 0) send_tick(1'($urandom_range(0, 3) == 0), 1'b0);
  endtask

  // Bring the block to rest: every result back, the measurement over (quiet
  // echo ends any wait by timeout at worst), and a few spare cycles.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    while (!ranger_idle) send_tick(1'b0, 1'b0);
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB: setup cycle, access cycle, done when pready is seen high
  task automatic reg_access(input logic write, input int unsigned index,
                            input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= PADDR_W'(index * 4);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write all four registers (upper bits beyond each width get dropped),
  // reading each one back right after the write.
  task automatic configure(input logic [PDATA_W-1:0] tmo, input logic [PDATA_W-1:0] max_cm,
                           input logic [PDATA_W-1:0] pre, input logic [PDATA_W-1:0] pulse);
    int unsigned        regs[4];
    logic [PDATA_W-1:0] vals[4];
    regs = '{REG_TIMEOUT, REG_MAX_DIST, REG_PRE_LOW, REG_PULSE};
    vals = '{tmo, max_cm, pre, pulse};
    for (int i = 0; i < 4; i++) begin
      reg_access(1'b1, regs[i], vals[i]);
      reg_access(1'b0, regs[i], '0);
    end
    reg_writes += 4;
    timeout_ticks = tmo[TIMEOUT_W-1:0];
    pre_low_ticks = pre[TICK8_W-1:0];
    pulse_ticks = pulse[TICK8_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls when enabled, plus one long counted hold-off on
  // request so the skid buffer fills and the input side backs up.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // hang guard
  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_end;
    int unsigned rise_wait;
    int unsigned high_len;
    int unsigned short_span;
    rst = 1'b1;
    in_valid = 1'b0;
    start_req = 1'b0;
    echo_level = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    timeout_ticks = 20'd30000;
    pre_low_ticks = 8'd5;
    pulse_ticks = 8'd15;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed, no idling on either side ---
    // register defaults after reset: 150 us echo gives 41 sixteenths
    measure(3, 150);
    settle();

    // tightest timing: no pre-low, zero pulse (still one high tick), 1 us timeout
    configure(32'd1, 32'd2, 32'd0, 32'd0);
    measure(0, 1);  // short echo lifts to the 2 cm floor
    measure(2, 1);  // echo rises on the last allowed tick
    measure(3, 2);  // rise wait runs out
    measure(0, 2);  // high for as long as allowed
    measure(0, 3);  // high time runs out
    settle();

    // ceiling below the floor wins; then ceiling masked down to zero
    configure(32'd1, 32'd1, 32'd0, 32'd1);
    measure(0, 1);
    settle();
    configure(32'd1, 32'hFFFF_FC00, 32'd0, 32'd1);
    measure(1, 2);
    settle();

    // widest timeout, upper data bits set everywhere: echo hits the 3 cm ceiling
    configure(32'hFFFF_FFFF, 32'hFFFF_FC03, 32'h0000_1203, 32'hABCD_EF04);
    measure(1, 200);
    settle();
    configure(32'hFFFF_FFFF, 32'd1023, 32'd1, 32'd1);
    measure(4, 250);  // 68 sixteenths, inside the clamps
    settle();

    // --- back-pressure: receiver holds off while the sender keeps offering ---
    configure(32'd200, 32'd400, 32'd2, 32'd3);
    hold_req = 1'b1;
    measure(4, 150);
    settle();  // sender pauses until every result is back

    // --- random phases: new settings, idling mix and measurements each time ---
    random_end = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < random_end) begin
      configure({12'($urandom),
                 20'(($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40))},
                {22'($urandom),
                 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(1, 30))},
                {24'($urandom),
                 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 60)
                                                : $urandom_range(0, 6))},
                {24'($urandom),
                 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 60)
                                                : $urandom_range(0, 6))});
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(6, 14)) begin
        if (ticks_sent >= random_end) break;
        if ($urandom_range(0, 6) == 0) begin
          // stray ticks, mostly while idle
          repeat ($urandom_range(1, 6)) send_tick(1'($urandom), 1'($urandom));
        end else begin
          short_span = (timeout_ticks < 30) ? timeout_ticks + 1 : 30;
          // now and then sit right on the timeout boundary
          if ($urandom_range(0, 4) == 0)
            rise_wait = timeout_ticks + $urandom_range(0, 2);
          else
            rise_wait = $urandom_range(0, short_span);
          case ($urandom_range(0, 4))
            0:       high_len = timeout_ticks + $urandom_range(0, 2);
            1:       high_len = $urandom_range(1, timeout_ticks + 1);
            default: high_len = $urandom_range(1, short_span);
          endcase
          measure(rise_wait, high_len);
        end
      end
      settle();
    end

    $display("Sent %0d ticks and %0d register writes (each read back).",
             ticks_sent, reg_writes);
    $display("Measurements finished: %0d, of which %0d ended by timeout.",
             done_count, timeout_count);
    if (failures == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
